FILE: sv/nmea_ubx_frame_sync_macros.svh
// shared assertion macros for the frame sync block
// each macro expects clk and rst in scope
`ifndef NMEA_UBX_FRAME_SYNC_MACROS_SVH
`define NMEA_UBX_FRAME_SYNC_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define NUFS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nufs check failed in same cycle");

// consequent checked in the cycle after the antecedent
`define NUFS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nufs check failed one cycle later");

`endif

FILE: sv/nufs_pkg.sv
`default_nettype none
package nufs_pkg;

  localparam logic [7:0] DOLLAR    = 8'h24;
  localparam logic [7:0] SYNC1     = 8'hB5;
  localparam logic [7:0] SYNC2     = 8'h62;
  localparam logic [7:0] LINE_FEED = 8'h0A;

  localparam logic [7:0] MAX_LEN_RESET = 8'd99;

  localparam logic KIND_NMEA = 1'b0;
  localparam logic KIND_UBX  = 1'b1;

  // output queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_kind;
    logic       frame_first;
    logic       frame_last;
    logic       truncated;
  } result_t;

  // up to two result words produced by one input word
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage
`default_nettype wire

FILE: sv/nufs_decode.sv
`default_nettype none
`include "nmea_ubx_frame_sync_macros.svh"
module nufs_decode (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_wr_en,
  input  wire logic [7:0]     cfg_wr_data,
  input  wire logic           accept,
  input  wire logic [7:0]     in_byte,
  output nufs_pkg::push_t     push
);

  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_SYNC  = 3'd1;
  localparam logic [2:0] PH_NMEA  = 3'd2;
  localparam logic [2:0] PH_UHDR  = 3'd3;
  localparam logic [2:0] PH_UBODY = 3'd4;

  logic [7:0]  max_len;
  logic [2:0]  phase, phase_next;
  logic [2:0]  header_count, header_count_next;
  logic [7:0]  length_low, length_low_next;
  logic [16:0] bytes_left, bytes_left_next;
  logic [7:0]  sentence_count, sentence_count_next;

  logic [1:0]        cnt_raw;
  nufs_pkg::result_t r0, r1;
  logic [7:0]        sc_inc;
  logic [16:0]       bl_dec;

  assign sc_inc = sentence_count + 8'd1;
  assign bl_dec = (bytes_left != 17'd0) ? bytes_left - 17'd1 : bytes_left;

  always_comb begin
    phase_next          = phase;
    header_count_next   = header_count;
    length_low_next     = length_low;
    bytes_left_next     = bytes_left;
    sentence_count_next = sentence_count;
    cnt_raw             = 2'd0;
    r0                  = '0;
    r1                  = '0;
    unique case (phase)
      PH_HUNT, PH_SYNC: begin
        if (in_byte == nufs_pkg::DOLLAR) begin
          // sentence open; a cap below two closes it at once
          cnt_raw        = 2'd1;
          r0.out_byte    = nufs_pkg::DOLLAR;
          r0.frame_kind  = nufs_pkg::KIND_NMEA;
          r0.frame_first = 1'b1;
          if (8'd1 >= max_len) begin
            r0.frame_last       = 1'b1;
            r0.truncated        = 1'b1;
            sentence_count_next = 8'd0;
            phase_next          = PH_HUNT;
          end else begin
            sentence_count_next = 8'd1;
            phase_next          = PH_NMEA;
          end
        end else if (in_byte == nufs_pkg::SYNC1) begin
          phase_next = PH_SYNC;
        end else if (phase == PH_SYNC && in_byte == nufs_pkg::SYNC2) begin
          cnt_raw           = 2'd2;
          r0.out_byte       = nufs_pkg::SYNC1;
          r0.frame_kind     = nufs_pkg::KIND_UBX;
          r0.frame_first    = 1'b1;
          r1.out_byte       = nufs_pkg::SYNC2;
          r1.frame_kind     = nufs_pkg::KIND_UBX;
          header_count_next = 3'd0;
          phase_next        = PH_UHDR;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_NMEA: begin
        cnt_raw       = 2'd1;
        r0.out_byte   = in_byte;
        r0.frame_kind = nufs_pkg::KIND_NMEA;
        if (in_byte == nufs_pkg::LINE_FEED) begin
          r0.frame_last       = 1'b1;
          sentence_count_next = 8'd0;
          phase_next          = PH_HUNT;
        end else if (sc_inc >= max_len) begin
          r0.frame_last       = 1'b1;
          r0.truncated        = 1'b1;
          sentence_count_next = 8'd0;
          phase_next          = PH_HUNT;
        end else begin
          sentence_count_next = sc_inc;
        end
      end
      PH_UHDR: begin
        cnt_raw       = 2'd1;
        r0.out_byte   = in_byte;
        r0.frame_kind = nufs_pkg::KIND_UBX;
        if (header_count == 3'd2) begin
          length_low_next = in_byte;
        end
        if (header_count >= 3'd3) begin
          // payload plus two checksum bytes
          bytes_left_next   = {1'b0, in_byte, length_low} + 17'd2;
          header_count_next = 3'd0;
          phase_next        = PH_UBODY;
        end else begin
          header_count_next = header_count + 3'd1;
        end
      end
      PH_UBODY: begin
        cnt_raw         = 2'd1;
        r0.out_byte     = in_byte;
        r0.frame_kind   = nufs_pkg::KIND_UBX;
        bytes_left_next = bl_dec;
        if (bl_dec == 17'd0) begin
          r0.frame_last = 1'b1;
          phase_next    = PH_HUNT;
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  assign push.cnt = accept ? cnt_raw : 2'd0;
  assign push.r0  = r0;
  assign push.r1  = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= nufs_pkg::MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      header_count   <= 3'd0;
      length_low     <= 8'd0;
      bytes_left     <= 17'd0;
      sentence_count <= 8'd0;
    end else if (accept) begin
      phase          <= phase_next;
      header_count   <= header_count_next;
      length_low     <= length_low_next;
      bytes_left     <= bytes_left_next;
      sentence_count <= sentence_count_next;
    end
  end

  `NUFS_ASSERT_NOW(a_pair_only_on_sync, push.cnt == 2'd2, phase == PH_SYNC && in_byte == nufs_pkg::SYNC2)
  `NUFS_ASSERT_NOW(a_trunc_ends_nmea, push.cnt != 2'd0 && push.r0.truncated, push.r0.frame_last && push.r0.frame_kind == nufs_pkg::KIND_NMEA)
  `NUFS_ASSERT_NEXT(a_last_back_to_hunt, push.cnt != 2'd0 && push.r0.frame_last, phase == PH_HUNT)

endmodule
`default_nettype wire

FILE: sv/nufs_out_fifo.sv
`default_nettype none
`include "nmea_ubx_frame_sync_macros.svh"
module nufs_out_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire nufs_pkg::push_t   push,
  input  wire logic              pop,
  output logic                   room2,
  output logic                   not_empty,
  output nufs_pkg::result_t      head
);

  nufs_pkg::result_t mem [nufs_pkg::FIFO_DEPTH];

  logic [nufs_pkg::FIFO_AW-1:0] wr_ptr, wr_ptr_next, wr_ptr_p1;
  logic [nufs_pkg::FIFO_AW-1:0] rd_ptr, rd_ptr_next;
  logic [nufs_pkg::FIFO_CW-1:0] count, count_next;

  assign wr_ptr_p1   = wr_ptr + nufs_pkg::FIFO_AW'(1);
  assign wr_ptr_next = wr_ptr + nufs_pkg::FIFO_AW'(push.cnt);
  assign rd_ptr_next = rd_ptr + nufs_pkg::FIFO_AW'(pop);
  assign count_next  = count + nufs_pkg::FIFO_CW'(push.cnt) - nufs_pkg::FIFO_CW'(pop);

  // room for a full pair of words
  assign room2     = count <= nufs_pkg::FIFO_CW'(nufs_pkg::FIFO_DEPTH - 2);
  assign not_empty = count != '0;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr_p1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  `NUFS_ASSERT_NOW(a_count_bound, 1'b1, count <= nufs_pkg::FIFO_CW'(nufs_pkg::FIFO_DEPTH))
  `NUFS_ASSERT_NOW(a_push_has_room, push.cnt != 2'd0, room2)
  `NUFS_ASSERT_NEXT(a_pop_drains, pop && push.cnt == 2'd0, count == $past(count) - nufs_pkg::FIFO_CW'(1))

endmodule
`default_nettype wire

FILE: sv/nmea_ubx_frame_sync.sv
// channel   direction  handshake             payload
// in        sink       in_valid / in_stall   in_byte
// out       source     out_valid / out_stall out_byte, frame_kind, frame_first,
//                                            frame_last, truncated
// cfg       sink       cfg_wr_en             cfg_wr_data (max_sentence_len)
//
// one input byte is taken per cycle while in_stall is low; its words are in the output queue the next cycle
// the 0x62 that completes a ubx sync yields two words, drained one per cycle while out_stall is low
// in_stall rises when the four-word output queue has no room for a pair
// rst is synchronous: hunt phase, empty queue, sentence cap back to 99
`default_nettype none
module nmea_ubx_frame_sync (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            frame_kind,
  output logic            frame_first,
  output logic            frame_last,
  output logic            truncated
);

  nufs_pkg::push_t   push;
  nufs_pkg::result_t head;
  logic              room2;
  logic              accept;
  logic              pop;

  assign in_stall = !room2;
  assign accept   = in_valid && room2;
  assign pop      = out_valid && !out_stall;

  nufs_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .in_byte     (in_byte),
    .push        (push)
  );

  nufs_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .room2     (room2),
    .not_empty (out_valid),
    .head      (head)
  );

  assign out_byte    = head.out_byte;
  assign frame_kind  = head.frame_kind;
  assign frame_first = head.frame_first;
  assign frame_last  = head.frame_last;
  assign truncated   = head.truncated;

endmodule
`default_nettype wire

FILE: sim/nmea_ubx_frame_check.sv
`timescale 1ns / 100ps
module nmea_ubx_frame_check (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       frame_kind,
  input  logic       frame_first,
  input  logic       frame_last,
  input  logic       truncated,
  output int         mismatches,
  output int         words_pending
);

  typedef enum logic [2:0] {
    HUNTING,
    SAW_SYNC1,
    IN_SENTENCE,
    IN_UBX_HEADER,
    IN_UBX_BODY
  } sync_phase_t;

  sync_phase_t  phase;
  logic [2:0]   hdr_taken;
  logic [7:0]   len_lo;
  logic [16:0]  body_left;
  logic [7:0]   nmea_count;
  logic [7:0]   cap;

  nufs_pkg::result_t framed_words [$];
  nufs_pkg::result_t seen;
  nufs_pkg::result_t want;

  initial begin
    mismatches    = 0;
    words_pending = 0;
  end

  function automatic void push_word(input logic [7:0] b, input logic kind,
                                    input logic first, input logic last,
                                    input logic trunc);
    nufs_pkg::result_t w;
    w.out_byte    = b;
    w.frame_kind  = kind;
    w.frame_first = first;
    w.frame_last  = last;
    w.truncated   = trunc;
    framed_words.insert(framed_words.size(), w);
  endfunction

  function automatic void open_sentence();
    nmea_count = 8'd1;
    if (nmea_count >= cap) begin
      push_word(nufs_pkg::DOLLAR, nufs_pkg::KIND_NMEA, 1'b1, 1'b1, 1'b1);
      nmea_count = 8'd0;
      phase      = HUNTING;
    end else begin
      push_word(nufs_pkg::DOLLAR, nufs_pkg::KIND_NMEA, 1'b1, 1'b0, 1'b0);
      phase = IN_SENTENCE;
    end
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    case (phase)
      HUNTING: begin
        if (b == nufs_pkg::DOLLAR) open_sentence();
        else if (b == nufs_pkg::SYNC1) phase = SAW_SYNC1;
      end
      SAW_SYNC1: begin
        if (b == nufs_pkg::DOLLAR) begin
          open_sentence();
        end else if (b == nufs_pkg::SYNC2) begin
          push_word(nufs_pkg::SYNC1, nufs_pkg::KIND_UBX, 1'b1, 1'b0, 1'b0);
          push_word(nufs_pkg::SYNC2, nufs_pkg::KIND_UBX, 1'b0, 1'b0, 1'b0);
          hdr_taken = 3'd0;
          phase     = IN_UBX_HEADER;
        end else if (b != nufs_pkg::SYNC1) begin
          phase = HUNTING;
        end
      end
      IN_SENTENCE: begin
        nmea_count = nmea_count + 8'd1;
        if (b == nufs_pkg::LINE_FEED) begin
          push_word(b, nufs_pkg::KIND_NMEA, 1'b0, 1'b1, 1'b0);
          nmea_count = 8'd0;
          phase      = HUNTING;
        end else if (nmea_count >= cap) begin
          push_word(b, nufs_pkg::KIND_NMEA, 1'b0, 1'b1, 1'b1);
          nmea_count = 8'd0;
          phase      = HUNTING;
        end else begin
          push_word(b, nufs_pkg::KIND_NMEA, 1'b0, 1'b0, 1'b0);
        end
      end
      IN_UBX_HEADER: begin
        push_word(b, nufs_pkg::KIND_UBX, 1'b0, 1'b0, 1'b0);
        if (hdr_taken == 3'd2) len_lo = b;
        if (hdr_taken >= 3'd3) begin
          // payload length is little endian, two checksum bytes follow it
          body_left = {1'b0, b, len_lo} + 17'd2;
          hdr_taken = 3'd0;
          phase     = IN_UBX_BODY;
        end else begin
          hdr_taken = hdr_taken + 3'd1;
        end
      end
      IN_UBX_BODY: begin
        if (body_left != 17'd0) body_left = body_left - 17'd1;
        if (body_left == 17'd0) begin
          push_word(b, nufs_pkg::KIND_UBX, 1'b0, 1'b1, 1'b0);
          phase = HUNTING;
        end else begin
          push_word(b, nufs_pkg::KIND_UBX, 1'b0, 1'b0, 1'b0);
        end
      end
      default: phase = HUNTING;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      phase      = HUNTING;
      hdr_taken  = 3'd0;
      len_lo     = 8'd0;
      body_left  = 17'd0;
      nmea_count = 8'd0;
      cap        = nufs_pkg::MAX_LEN_RESET;
      framed_words.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen.out_byte    = out_byte;
        seen.frame_kind  = frame_kind;
        seen.frame_first = frame_first;
        seen.frame_last  = frame_last;
        seen.truncated   = truncated;
        if (framed_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: byte %02h kind %0d first %0d last %0d trunc %0d",
                     seen.out_byte, seen.frame_kind, seen.frame_first,
                     seen.frame_last, seen.truncated);
        end else begin
          want = framed_words.pop_front();
          if (seen.out_byte != want.out_byte || seen.frame_kind != want.frame_kind ||
              seen.frame_first != want.frame_first ||
              seen.frame_last != want.frame_last || seen.truncated != want.truncated) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected byte %02h kind %0d first %0d last %0d trunc %0d,",
                       want.out_byte, want.frame_kind, want.frame_first,
                       want.frame_last, want.truncated,
                       " got byte %02h kind %0d first %0d last %0d trunc %0d",
                       seen.out_byte, seen.frame_kind, seen.frame_first,
                       seen.frame_last, seen.truncated);
          end
        end
      end
      if (in_valid && !in_stall) deframe_byte(in_byte);
      if (cfg_wr_en) cap = cfg_wr_data;
    end
    words_pending = framed_words.size();
  end

endmodule

FILE: sim/nmea_ubx_frame_sync_test.sv
`timescale 1ns / 100ps
module nmea_ubx_frame_sync_test;

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       frame_kind;
  logic       frame_first;
  logic       frame_last;
  logic       truncated;

  int mismatches;
  int words_pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int framed_bytes  = 0;
  int cur_cap       = 99;

  nmea_ubx_frame_sync u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .frame_kind  (frame_kind),
    .frame_first (frame_first),
    .frame_last  (frame_last),
    .truncated   (truncated)
  );

  nmea_ubx_frame_check u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .frame_kind    (frame_kind),
    .frame_first   (frame_first),
    .frame_last    (frame_last),
    .truncated     (truncated),
    .mismatches    (mismatches),
    .words_pending (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(2_000_000);
    $display("FAIL");
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = ($urandom_range(99) < recv_idle_pct);
    end
  end

  // entered and left at a falling edge
  task automatic put_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte  = b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (words_pending != 0) @(negedge clk);
    // a sync byte still in flight yields nothing, give it time to settle
    repeat (8) @(negedge clk);
  endtask

  task automatic change_cap(input logic [7:0] v);
    drain();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    cur_cap   = int'(v);
  endtask

  task automatic send_sentence(input int body_len);
    logic [7:0] b;
    put_byte(nufs_pkg::DOLLAR);
    repeat (body_len) begin
      b = 8'($urandom_range(255));
      if (b == nufs_pkg::LINE_FEED) b = nufs_pkg::DOLLAR;
      put_byte(b);
    end
    put_byte(nufs_pkg::LINE_FEED);
    framed_bytes += body_len + 2;
  endtask

  task automatic send_ubx(input int pay_len);
    put_byte(nufs_pkg::SYNC1);
    put_byte(nufs_pkg::SYNC2);
    put_byte(8'($urandom_range(255)));
    put_byte(8'($urandom_range(255)));
    put_byte(pay_len[7:0]);
    put_byte(pay_len[15:8]);
    repeat (pay_len + 2) put_byte(8'($urandom_range(255)));
    framed_bytes += pay_len + 8;
  endtask

  function automatic int sentence_len();
    int pick;
    pick = int'($urandom_range(9));
    if (pick <= 5) return int'($urandom_range(12));
    if (pick == 6) return (cur_cap >= 2) ? cur_cap - 2 : 0;  // line feed lands on the cap
    if (pick == 7) return (cur_cap >= 1) ? cur_cap - 1 : 0;
    if (pick == 8) return cur_cap + int'($urandom_range(4));
    return int'($urandom_range(40));
  endfunction

  function automatic int ubx_len();
    int pick;
    pick = int'($urandom_range(9));
    if (pick == 0) return 0;
    if (pick == 1) return int'($urandom_range(300));
    return int'($urandom_range(16));
  endfunction

  task automatic run_traffic(input int n_bytes);
    int stop_at;
    int pick;
    logic [7:0] b;
    stop_at = framed_bytes + n_bytes;
    while (framed_bytes < stop_at) begin
      pick = int'($urandom_range(99));
      if (pick < 40) begin
        send_sentence(sentence_len());
      end else if (pick < 75) begin
        send_ubx(ubx_len());
      end else if (pick < 82) begin
        put_byte(nufs_pkg::SYNC1);
        send_ubx(ubx_len());
      end else if (pick < 88) begin
        put_byte(nufs_pkg::SYNC1);
        send_sentence(sentence_len());
      end else if (pick < 93) begin
        put_byte(nufs_pkg::SYNC1);
        do b = 8'($urandom_range(255));
        while (b == nufs_pkg::DOLLAR || b == nufs_pkg::SYNC1 || b == nufs_pkg::SYNC2);
        put_byte(b);
      end else begin
        do b = 8'($urandom_range(255)); while (b == nufs_pkg::DOLLAR || b == nufs_pkg::SYNC1);
        put_byte(b);
      end
    end
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_byte     = 8'h00;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 8'h00;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 22;
    recv_idle_pct = 59;

    // dropped noise, then a sentence carrying a dollar inside
    put_byte(8'hFF);
    put_byte(nufs_pkg::DOLLAR); put_byte(8'h00); put_byte(8'hFF); put_byte(nufs_pkg::DOLLAR);
    put_byte(nufs_pkg::LINE_FEED);
    // repeated sync byte, then a frame with zero payload
    put_byte(nufs_pkg::SYNC1); put_byte(nufs_pkg::SYNC1); put_byte(nufs_pkg::SYNC2);
    put_byte(8'h01); put_byte(8'h02); put_byte(8'h00); put_byte(8'h00);
    put_byte(8'hAA); put_byte(8'hBB);
    // dollar right after the sync byte, then an unrelated byte after it
    put_byte(nufs_pkg::SYNC1); put_byte(nufs_pkg::DOLLAR); put_byte(nufs_pkg::LINE_FEED);
    put_byte(nufs_pkg::SYNC1); put_byte(8'h11);
    // caps below two end the sentence at the dollar
    change_cap(8'd1);
    put_byte(nufs_pkg::DOLLAR);
    change_cap(8'd0);
    put_byte(nufs_pkg::DOLLAR);

    change_cap(8'd8);
    run_traffic(400);

    change_cap(8'd255);
    send_idle_pct = 59;
    recv_idle_pct = 22;
    run_traffic(400);

    change_cap(8'($urandom_range(255, 8)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_traffic(250);
    change_cap(8'd20);
    run_traffic(150);

    // largest payload length, left open after a few payload bytes
    put_byte(nufs_pkg::SYNC1); put_byte(nufs_pkg::SYNC2);
    put_byte(8'h06); put_byte(8'h01); put_byte(8'hFF); put_byte(8'hFF);
    repeat (20) put_byte(8'($urandom_range(255)));

    drain();
    if (mismatches == 0 && words_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/nufs_pkg.sv
sv/nufs_decode.sv
sv/nufs_out_fifo.sv
sv/nmea_ubx_frame_sync.sv
sim/nmea_ubx_frame_check.sv
sim/nmea_ubx_frame_sync_test.sv
